[hw/rtl/bqd_pkg.sv]
// ----------------------------------------------------------------------------
// bqd_pkg
// Shared types and constants of the biquad filter core: datapath command
// encoding, controller states, register indexes and fixed widths.
// ----------------------------------------------------------------------------
package bqd_pkg;

    localparam int COEF_BITS  = 32;
    localparam int STATE_BITS = 32;
    localparam int PROD_BITS  = 2 * COEF_BITS;
    localparam int ACC_BITS   = PROD_BITS + 2;
    localparam int CFG_IDX_BITS = 3;

    localparam logic [CFG_IDX_BITS-1:0] REG_B0 = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_B1 = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_B2 = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_A1 = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] REG_A2 = 3'd4;

    typedef enum logic [3:0] {
        S_IDLE,
        S_A1,
        S_A2,
        S_A2_ACC,
        S_W,
        S_B0,
        S_B1,
        S_B2,
        S_B2_ACC,
        S_FIN
    } t_state;

    typedef enum logic [2:0] {
        ACC_HOLD,
        ACC_LOAD_X,
        ACC_SUB,
        ACC_ADD,
        ACC_LOAD_HALF
    } t_acc_op;

    typedef enum logic [2:0] {
        MUL_A1,
        MUL_A2,
        MUL_B0,
        MUL_B1,
        MUL_B2
    } t_mul_sel;

    typedef struct packed {
        t_acc_op  acc_op;
        t_mul_sel mul_sel;
        logic     mul_en;
        logic     w_load;
        logic     out_load;
    } t_dp_cmd;

endpackage

[hw/rtl/bqd_ctrl.sv]
// ----------------------------------------------------------------------------
// bqd_ctrl
// Sequencer of the biquad core: steps the shared multiplier and accumulator
// through the feedback and feedforward terms, and owns the handshakes.
// ----------------------------------------------------------------------------
module bqd_ctrl
    import bqd_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    output logic    o_stall,
    output logic    o_valid,
    input  logic    i_stall,
    output t_dp_cmd o_cmd
);

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   in_fire;
    logic   out_free;

    assign in_fire  = i_valid && (r_state == S_IDLE);
    assign out_free = !r_out_valid || !i_stall;
    assign o_stall  = (r_state != S_IDLE);
    assign o_valid  = r_out_valid;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:   if (i_valid) n_state = S_A1;
            S_A1:     n_state = S_A2;
            S_A2:     n_state = S_A2_ACC;
            S_A2_ACC: n_state = S_W;
            S_W:      n_state = S_B0;
            S_B0:     n_state = S_B1;
            S_B1:     n_state = S_B2;
            S_B2:     n_state = S_B2_ACC;
            S_B2_ACC: n_state = S_FIN;
            S_FIN:    if (out_free) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd          = '0;
        o_cmd.acc_op   = ACC_HOLD;
        o_cmd.mul_sel  = MUL_A1;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) o_cmd.acc_op = ACC_LOAD_X;
            end
            S_A1: begin
                o_cmd.mul_sel = MUL_A1;
                o_cmd.mul_en  = 1'b1;
            end
            S_A2: begin
                o_cmd.mul_sel = MUL_A2;
                o_cmd.mul_en  = 1'b1;
                o_cmd.acc_op  = ACC_SUB;
            end
            S_A2_ACC: begin
                o_cmd.acc_op = ACC_SUB;
            end
            S_W: begin
                o_cmd.w_load = 1'b1;
                o_cmd.acc_op = ACC_LOAD_HALF;
            end
            S_B0: begin
                o_cmd.mul_sel = MUL_B0;
                o_cmd.mul_en  = 1'b1;
            end
            S_B1: begin
                o_cmd.mul_sel = MUL_B1;
                o_cmd.mul_en  = 1'b1;
                o_cmd.acc_op  = ACC_ADD;
            end
            S_B2: begin
                o_cmd.mul_sel = MUL_B2;
                o_cmd.mul_en  = 1'b1;
                o_cmd.acc_op  = ACC_ADD;
            end
            S_B2_ACC: begin
                o_cmd.acc_op = ACC_ADD;
            end
            S_FIN: begin
                o_cmd.out_load = out_free;
            end
            default: begin
                o_cmd.acc_op = ACC_HOLD;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (r_out_valid && !i_stall) n_out_valid = 1'b0;
        if (o_cmd.out_load) n_out_valid = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // fixed schedule from accepted beat to final step
    a_schedule: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire |-> ##9 (r_state == S_FIN))
        else $error("bqd_ctrl: schedule broken");

    // a waiting result is never overwritten
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |-> (!r_out_valid || !i_stall))
        else $error("bqd_ctrl: result overwritten");

    // finishing a sample always presents a beat
    a_result_shown: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |=> r_out_valid)
        else $error("bqd_ctrl: result lost");

    // only one sample in flight
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire |=> o_stall)
        else $error("bqd_ctrl: second sample taken");

endmodule

[hw/rtl/bqd_dp.sv]
// ----------------------------------------------------------------------------
// bqd_dp
// Datapath of the biquad core: coefficient registers, delay state, one
// 32x32 multiplier with product register, wide accumulator, rounding and
// saturation.
// ----------------------------------------------------------------------------
module bqd_dp
    import bqd_pkg::*;
#(
    parameter int SAMPLE_BITS    = 24,
    parameter int COEF_FRAC_BITS = 28
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_dp_cmd                 i_cmd,
    input  logic                    i_cfg_we,
    input  logic [CFG_IDX_BITS-1:0] i_cfg_index,
    input  logic [COEF_BITS-1:0]    i_cfg_data,
    input  logic [SAMPLE_BITS-1:0]  i_sample_in,
    output logic [SAMPLE_BITS-1:0]  o_sample_out
);

    localparam logic [COEF_BITS-1:0] COEF_ONE =
        {{(COEF_BITS-COEF_FRAC_BITS-1){1'b0}}, 1'b1, {COEF_FRAC_BITS{1'b0}}};
    localparam logic signed [ACC_BITS-1:0] HALF =
        {{(ACC_BITS-COEF_FRAC_BITS){1'b0}}, 1'b1, {(COEF_FRAC_BITS-1){1'b0}}};
    localparam logic signed [ACC_BITS-1:0] W_MAX =
        {{(ACC_BITS-STATE_BITS+1){1'b0}}, {(STATE_BITS-1){1'b1}}};
    localparam logic signed [ACC_BITS-1:0] W_MIN = ~W_MAX;
    localparam logic signed [ACC_BITS-1:0] Y_MAX =
        {{(ACC_BITS-SAMPLE_BITS+1){1'b0}}, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic signed [ACC_BITS-1:0] Y_MIN = ~Y_MAX;

    logic signed [COEF_BITS-1:0]  r_b0, r_b1, r_b2, r_a1, r_a2;
    logic signed [STATE_BITS-1:0] r_d1, r_d2, r_w;
    logic signed [PROD_BITS-1:0]  r_prod;
    logic signed [ACC_BITS-1:0]   r_acc;
    logic [SAMPLE_BITS-1:0]       r_out;

    logic signed [COEF_BITS-1:0]  op_coef;
    logic signed [STATE_BITS-1:0] op_state;
    logic signed [ACC_BITS-1:0]   prod_ext;
    logic signed [ACC_BITS-1:0]   x_ext;
    logic signed [ACC_BITS-1:0]   quot;
    logic signed [ACC_BITS-1:0]   w_sat;
    logic signed [ACC_BITS-1:0]   y_sat;

    // config register file
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b0 <= COEF_ONE;
            r_b1 <= '0;
            r_b2 <= '0;
            r_a1 <= '0;
            r_a2 <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_B0:  r_b0 <= i_cfg_data;
                REG_B1:  r_b1 <= i_cfg_data;
                REG_B2:  r_b2 <= i_cfg_data;
                REG_A1:  r_a1 <= i_cfg_data;
                REG_A2:  r_a2 <= i_cfg_data;
                default: r_b0 <= r_b0;
            endcase
        end
    end

    always_comb begin
        unique case (i_cmd.mul_sel)
            MUL_A1: begin
                op_coef  = r_a1;
                op_state = r_d1;
            end
            MUL_A2: begin
                op_coef  = r_a2;
                op_state = r_d2;
            end
            MUL_B0: begin
                op_coef  = r_b0;
                op_state = r_w;
            end
            MUL_B1: begin
                op_coef  = r_b1;
                op_state = r_d1;
            end
            MUL_B2: begin
                op_coef  = r_b2;
                op_state = r_d2;
            end
            default: begin
                op_coef  = r_b0;
                op_state = r_w;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_en) r_prod <= op_coef * op_state;
    end

    assign prod_ext = {{(ACC_BITS-PROD_BITS){r_prod[PROD_BITS-1]}}, r_prod};
    assign x_ext    = {{(ACC_BITS-SAMPLE_BITS){i_sample_in[SAMPLE_BITS-1]}}, i_sample_in};

    always_ff @(posedge i_clk) begin
        unique case (i_cmd.acc_op)
            ACC_LOAD_X:    r_acc <= (x_ext <<< COEF_FRAC_BITS) + HALF;
            ACC_SUB:       r_acc <= r_acc - prod_ext;
            ACC_ADD:       r_acc <= r_acc + prod_ext;
            ACC_LOAD_HALF: r_acc <= HALF;
            default:       r_acc <= r_acc;
        endcase
    end

    // floor after the half bias gives round half up
    assign quot = r_acc >>> COEF_FRAC_BITS;

    always_comb begin
        if (quot > W_MAX) begin
            w_sat = W_MAX;
        end else if (quot < W_MIN) begin
            w_sat = W_MIN;
        end else begin
            w_sat = quot;
        end
    end

    always_comb begin
        if (quot > Y_MAX) begin
            y_sat = Y_MAX;
        end else if (quot < Y_MIN) begin
            y_sat = Y_MIN;
        end else begin
            y_sat = quot;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.w_load) r_w <= w_sat[STATE_BITS-1:0];
        if (i_cmd.out_load) r_out <= y_sat[SAMPLE_BITS-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d1 <= '0;
            r_d2 <= '0;
        end else if (i_cmd.out_load) begin
            r_d1 <= r_w;
            r_d2 <= r_d1;
        end
    end

    assign o_sample_out = r_out;

endmodule

[hw/rtl/biquad_iir_filter_core.sv]
// ----------------------------------------------------------------------------
// biquad_iir_filter_core
// Second-order direct form II IIR filter with saturating state and output.
// ----------------------------------------------------------------------------
// Each accepted input beat runs to the result register as five
// multiply-accumulates, one after another through a single registered
// 32x32 multiplier, with rounding and saturation of the state between the
// feedback and feedforward halves. A new sample is taken only once the
// previous result is stored, so samples do not overlap in the datapath;
// the result register lets the next sample start while the last one
// still waits to be taken.
// Coefficients are signed Q4.28 (fraction bits set by COEF_FRAC_BITS) at
// register indexes b0, b1, b2, a1, a2 = 0..4; b0 resets to unity.
module biquad_iir_filter_core
    import bqd_pkg::*;
#(
    parameter int SAMPLE_BITS    = 24,
    parameter int COEF_FRAC_BITS = 28
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_stall,
    input  logic [SAMPLE_BITS-1:0]  i_sample_in,
    output logic                    o_valid,
    input  logic                    i_stall,
    output logic [SAMPLE_BITS-1:0]  o_sample_out,
    input  logic                    i_cfg_we,
    input  logic [CFG_IDX_BITS-1:0] i_cfg_index,
    input  logic [COEF_BITS-1:0]    i_cfg_data
);

    t_dp_cmd cmd;

    bqd_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_cmd   (cmd)
    );

    bqd_dp #(
        .SAMPLE_BITS    (SAMPLE_BITS),
        .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_sample_in  (i_sample_in),
        .o_sample_out (o_sample_out)
    );

endmodule

[dv/biquad_iir_filter_core_test.sv]
// ----------------------------------------------------------------------------
// biquad_iir_filter_core_test
// Self-checking bench for the direct form II biquad core. A bit-exact
// predictor tracks the coefficients and the two delay words and works out
// each filtered sample, and every output beat is checked against the oldest
// prediction. A directed opening covers unity pass, sample extremes, state
// and output saturation, half-up rounding and ignored register indexes;
// random phases then vary coefficients, sample mix, sender bursts and
// receiver stalls.
// ----------------------------------------------------------------------------
module biquad_iir_filter_core_test
    import bqd_pkg::*;
();

    localparam int SAMPLE_BITS = 24;
    localparam int FRAC_BITS   = 28;
    localparam int ITEMS       = 1400;
    localparam int PHASES      = 10;
    localparam int CYCLE_LIMIT = 600000;
    localparam int SETTLE      = 12;

    localparam logic [COEF_BITS-1:0] Q_ONE   = 32'h1000_0000;
    localparam logic [COEF_BITS-1:0] Q_HALF  = 32'h0800_0000;
    localparam logic [COEF_BITS-1:0] Q_MAX   = 32'h7fff_ffff;
    localparam logic [COEF_BITS-1:0] Q_MIN   = 32'h8000_0000;
    localparam logic [COEF_BITS-1:0] Q_NEG1  = 32'hf000_0000;

    localparam logic [SAMPLE_BITS-1:0] X_MAX = 24'h7f_ffff;
    localparam logic [SAMPLE_BITS-1:0] X_MIN = 24'h80_0000;

    localparam logic signed [65:0] W_MAX = 66'sd2147483647;
    localparam logic signed [65:0] W_MIN = -66'sd2147483648;
    localparam logic signed [65:0] Y_MAX = 66'sd8388607;
    localparam logic signed [65:0] Y_MIN = -66'sd8388608;

    class biquad_sb;
        logic signed [65:0] b0, b1, b2, a1, a2;
        logic signed [65:0] w1, w2;
        logic [SAMPLE_BITS-1:0] due_q[$];
        int errors;

        function new();
            b0 = 66'sd1 <<< FRAC_BITS;
            b1 = '0;
            b2 = '0;
            a1 = '0;
            a2 = '0;
            w1 = '0;
            w2 = '0;
            errors = 0;
        endfunction

        function void write_coef(logic [CFG_IDX_BITS-1:0] idx, logic [COEF_BITS-1:0] data);
            logic signed [65:0] v;
            v = 66'($signed(data));
            case (idx)
                REG_B0: b0 = v;
                REG_B1: b1 = v;
                REG_B2: b2 = v;
                REG_A1: a1 = v;
                REG_A2: a2 = v;
                default: ;
            endcase
        endfunction

        // exact sums, floor after adding one half, then saturate
        function logic [SAMPLE_BITS-1:0] filter_step(logic [SAMPLE_BITS-1:0] x);
            logic signed [65:0] acc, w, y, half;
            half = 66'sd1 <<< (FRAC_BITS - 1);
            acc = 66'($signed(x));
            acc = (acc <<< FRAC_BITS) - a1 * w1 - a2 * w2 + half;
            w = acc >>> FRAC_BITS;
            if (w > W_MAX) w = W_MAX;
            else if (w < W_MIN) w = W_MIN;
            acc = b0 * w + b1 * w1 + b2 * w2 + half;
            y = acc >>> FRAC_BITS;
            if (y > Y_MAX) y = Y_MAX;
            else if (y < Y_MIN) y = Y_MIN;
            w2 = w1;
            w1 = w;
            return y[SAMPLE_BITS-1:0];
        endfunction

        function void note_sample(logic [SAMPLE_BITS-1:0] x);
            due_q.push_back(filter_step(x));
        endfunction

        function int pending();
            return due_q.size();
        endfunction

        task report(string msg);
            if (errors < 50) $display("mismatch: %s", msg);
            errors++;
        endtask

        task check_sample(logic [SAMPLE_BITS-1:0] got);
            logic [SAMPLE_BITS-1:0] want;
            if (due_q.size() == 0) begin
                report($sformatf("output beat %0d with no sample due", $signed(got)));
            end else begin
                want = due_q.pop_front();
                if (got !== want)
                    report($sformatf("sample_out %0d, expected %0d",
                                     $signed(got), $signed(want)));
            end
        endtask
    endclass

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    i_valid = 1'b0;
    logic                    i_stall = 1'b0;
    logic                    i_cfg_we = 1'b0;
    logic [SAMPLE_BITS-1:0]  i_sample_in = '0;
    logic [CFG_IDX_BITS-1:0] i_cfg_index = '0;
    logic [COEF_BITS-1:0]    i_cfg_data = '0;
    logic                    o_stall;
    logic                    o_valid;
    logic [SAMPLE_BITS-1:0]  o_sample_out;

    int cycles = 0;
    int stall_pct = 0;
    int stall_span = 0;
    int stall_left = 0;

    biquad_sb sb;

    biquad_iir_filter_core #(
        .SAMPLE_BITS(SAMPLE_BITS),
        .COEF_FRAC_BITS(FRAC_BITS)
    ) uut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .o_stall(o_stall),
        .i_sample_in(i_sample_in),
        .o_valid(o_valid),
        .i_stall(i_stall),
        .o_sample_out(o_sample_out),
        .i_cfg_we(i_cfg_we),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data(i_cfg_data)
    );

    always #4 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // output side: check accepted beats, stall in random runs
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) sb.check_sample(o_sample_out);
        if (stall_left > 0) begin
            stall_left--;
        end else begin
            stall_left = $urandom_range(0, stall_span);
            i_stall <= ($urandom_range(0, 99) < stall_pct);
        end
    end

    function automatic int srand(int lim);
        return int'($urandom_range(0, 2 * lim)) - lim;
    endfunction

    function automatic logic [SAMPLE_BITS-1:0] pick_sample();
        int r;
        logic [SAMPLE_BITS-1:0] s;
        r = $urandom_range(0, 99);
        if (r < 50) begin
            s = SAMPLE_BITS'($urandom());
        end else if (r < 65) begin
            case ($urandom_range(0, 4))
                0: s = X_MAX;
                1: s = X_MIN;
                2: s = '0;
                3: s = 24'd1;
                default: s = '1;
            endcase
        end else begin
            s = SAMPLE_BITS'(srand(1000));
        end
        return s;
    endfunction

    function automatic logic [COEF_BITS-1:0] pick_coef(int mode, logic [CFG_IDX_BITS-1:0] idx);
        logic [COEF_BITS-1:0] c;
        if (mode == 0) begin
            // mostly well-behaved filters
            if (idx == REG_A1) c = srand(510000000);
            else if (idx == REG_A2) c = srand(240000000);
            else c = srand(268435456);
        end else if (mode == 1) begin
            case ($urandom_range(0, 4))
                0: c = Q_MAX;
                1: c = Q_MIN;
                2: c = '0;
                3: c = Q_ONE;
                default: c = Q_NEG1;
            endcase
        end else begin
            c = $urandom();
        end
        return c;
    endfunction

    task automatic drive_sample(logic [SAMPLE_BITS-1:0] x);
        i_valid <= 1'b1;
        i_sample_in <= x;
        do @(posedge i_clk); while (o_stall);
        sb.note_sample(x);
    endtask

    task automatic hold_off(int n);
        i_valid <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (sb.pending() > 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [COEF_BITS-1:0] data);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        sb.write_coef(idx, data);
    endtask

    // all five coefficients plus one write to an unused index
    task automatic load_coefs(logic [COEF_BITS-1:0] b0, logic [COEF_BITS-1:0] b1,
                              logic [COEF_BITS-1:0] b2, logic [COEF_BITS-1:0] a1,
                              logic [COEF_BITS-1:0] a2);
        write_reg(REG_A2, a2);
        write_reg(REG_B1, b1);
        write_reg(3'($urandom_range(5, 7)), $urandom());
        write_reg(REG_B0, b0);
        write_reg(REG_A1, a1);
        write_reg(REG_B2, b2);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    initial begin
        int n;
        int burst;
        int mode;
        int gap_max;
        bit quiet;
        sb = new();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // unity pass out of reset
        drive_sample('0);
        drive_sample(X_MAX);
        drive_sample(X_MIN);
        drive_sample(24'd1);
        drive_sample('1);
        drive_sample(24'h55_5555);
        drive_sample(24'haa_aaaa);
        drain();

        // extreme coefficients: state and output saturation, ignored indexes
        load_coefs(Q_MAX, Q_MIN, Q_MAX, Q_MIN, Q_MAX);
        write_reg(3'd5, 32'h1234_5678);
        write_reg(3'd6, 32'hedcb_a987);
        write_reg(3'd7, Q_MIN);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
        repeat (3) drive_sample(X_MAX);
        repeat (3) drive_sample(X_MIN);
        drain();

        // half-up rounding on the output sum
        load_coefs(Q_HALF, '0, '0, '0, '0);
        drive_sample(24'd1);
        drive_sample('1);
        drive_sample(24'd3);
        drive_sample(-24'sd3);
        drain();

        // half-up rounding on the state sum
        load_coefs(Q_ONE, '0, '0, Q_HALF, '0);
        drive_sample(24'd1);
        drive_sample('0);
        drive_sample('1);
        drive_sample('0);
        drain();

        for (int phase = 0; phase < PHASES; phase++) begin
            mode = phase % 3;
            quiet = (phase % 4 == 0);
            stall_pct = quiet ? 0 : $urandom_range(10, 70);
            stall_span = $urandom_range(0, 12);
            case ($urandom_range(0, 2))
                0: gap_max = 2;
                1: gap_max = 8;
                default: gap_max = 25;
            endcase
            if (quiet) gap_max = 0;
            load_coefs(pick_coef(mode, REG_B0), pick_coef(mode, REG_B1),
                       pick_coef(mode, REG_B2), pick_coef(mode, REG_A1),
                       pick_coef(mode, REG_A2));
            n = 0;
            while (n < ITEMS / PHASES) begin
                burst = $urandom_range(1, 24);
                if (burst > ITEMS / PHASES - n) burst = ITEMS / PHASES - n;
                repeat (burst) begin
                    drive_sample(pick_sample());
                    n++;
                end
                if ($urandom_range(0, 19) == 0) drain();
                else if (gap_max > 0) hold_off($urandom_range(1, gap_max));
            end
            drain();
        end

        if (sb.pending() > 0) sb.report($sformatf("%0d samples never came", sb.pending()));
        if (sb.errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
